// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the balance controller rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== hw/rtl/bcp_pkg.sv =====
// types, constants, microcode table and helpers of the balance controller
package bcp_pkg;

  localparam int CFG_DATA_W  = 27;
  localparam int CFG_INDEX_W = 3;
  localparam int STEP_W      = 4;

  localparam int INTEGRAL_LIMIT = 10000;

  // ceil(2^24 / 10), exact quotient for dividends below 2^20
  localparam logic signed [26:0] RECIP_10 = 27'sd1677722;

  localparam logic signed [16:0] MID_ANGLE_RST    = -17'sd768;
  localparam logic signed [15:0] SPEED_GOAL_RST   = 16'sd0;
  localparam logic signed [26:0] UPRIGHT_KP_RST   = -27'sd14942208;
  localparam logic signed [26:0] UPRIGHT_KD_RST   = -27'sd47186;
  localparam logic signed [26:0] SPEED_KP_RST     = -27'sd21627;
  localparam logic signed [26:0] SPEED_KI_RST     = -27'sd98;
  localparam logic signed [26:0] TURN_GAIN_RST    = 27'sd85197;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MID_ANGLE    = 3'd0,
    REG_SPEED_GOAL   = 3'd1,
    REG_UPRIGHT_KP   = 3'd2,
    REG_UPRIGHT_KD   = 3'd3,
    REG_SPEED_KP     = 3'd4,
    REG_SPEED_KI     = 3'd5,
    REG_TURN_GAIN    = 3'd6
  } cfg_reg_e;

  typedef enum logic [2:0] {
    MA_RECIP,
    MA_SPEED_KP,
    MA_SPEED_KI,
    MA_TURN,
    MA_UP_KP,
    MA_UP_KD
  } mul_a_sel_e;

  typedef enum logic [2:0] {
    MB_NUM_ABS,
    MB_FILT,
    MB_INTEG,
    MB_RATE_YAW,
    MB_DIFF,
    MB_RATE_PITCH
  } mul_b_sel_e;

  typedef enum logic [3:0] {
    ALU_NOP,
    ALU_ERR,
    ALU_NUM,
    ALU_FILT,
    ALU_INTEG,
    ALU_ACC_LOAD,
    ALU_ACC_ADD,
    ALU_ACC_ADD_SH8,
    ALU_SPEED,
    ALU_DIFF,
    ALU_TURN,
    ALU_UPRIGHT,
    ALU_OUT
  } alu_op_e;

  typedef enum logic [1:0] {
    SEQ_NEXT,
    SEQ_WAIT_IN,
    SEQ_WAIT_OUT,
    SEQ_RESTART
  } seq_e;

  typedef struct packed {
    alu_op_e    alu;
    logic       mul_en;
    mul_a_sel_e mul_a;
    mul_b_sel_e mul_b;
    seq_e       seq;
  } ctrl_word_t;

  localparam logic [STEP_W-1:0] LAST_STEP = 4'd13;

  function automatic ctrl_word_t ucode(input logic [STEP_W-1:0] step);
    ctrl_word_t cw;
    cw = '{alu: ALU_NOP, mul_en: 1'b0, mul_a: MA_RECIP, mul_b: MB_NUM_ABS, seq: SEQ_NEXT};
    case (step)
      4'd0:  begin cw.alu = ALU_ERR; cw.seq = SEQ_WAIT_IN; end
      4'd1:  cw.alu = ALU_NUM;
      4'd2:  begin cw.mul_en = 1'b1; cw.mul_a = MA_RECIP; cw.mul_b = MB_NUM_ABS; end
      4'd3:  cw.alu = ALU_FILT;
      4'd4:  begin
        cw.alu = ALU_INTEG; cw.mul_en = 1'b1; cw.mul_a = MA_SPEED_KP; cw.mul_b = MB_FILT;
      end
      4'd5:  begin
        cw.alu = ALU_ACC_LOAD; cw.mul_en = 1'b1; cw.mul_a = MA_SPEED_KI; cw.mul_b = MB_INTEG;
      end
      4'd6:  cw.alu = ALU_ACC_ADD;
      4'd7:  cw.alu = ALU_SPEED;
      4'd8:  begin
        cw.alu = ALU_DIFF; cw.mul_en = 1'b1; cw.mul_a = MA_TURN; cw.mul_b = MB_RATE_YAW;
      end
      4'd9:  begin
        cw.alu = ALU_TURN; cw.mul_en = 1'b1; cw.mul_a = MA_UP_KP; cw.mul_b = MB_DIFF;
      end
      4'd10: begin
        cw.alu = ALU_ACC_LOAD; cw.mul_en = 1'b1; cw.mul_a = MA_UP_KD; cw.mul_b = MB_RATE_PITCH;
      end
      4'd11: cw.alu = ALU_ACC_ADD_SH8;
      4'd12: cw.alu = ALU_UPRIGHT;
      4'd13: begin cw.alu = ALU_OUT; cw.seq = SEQ_WAIT_OUT; end
      default: cw.seq = SEQ_RESTART;
    endcase
    return cw;
  endfunction

  // signed divide by 2^sh, rounded toward zero
  function automatic logic signed [53:0] trunc_pow2(input logic signed [53:0] v,
                                                    input int unsigned sh);
    logic signed [53:0] bias;
    bias = v[53] ? ((54'sd1 <<< sh) - 54'sd1) : 54'sd0;
    return (v + bias) >>> sh;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [53:0] v);
    logic signed [15:0] r;
    if (v > 54'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -54'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/balance_cascade_pid.sv =====
// cascaded speed pi / upright pd / turn p balance controller, microcoded datapath
//
//   channel   direction  handshake                  payload
//   in        sink       in_valid_i / in_stall_o    speed_left, speed_right, pitch,
//                                                    rate_pitch, rate_yaw
//   out       source     out_valid_o / out_stall_i  drive_left, drive_right, speed_term
//   cfg       sink       cfg_we_i                   cfg_index_i, cfg_data_i
//
// each item runs through an accept step and 13 microcode steps that share
// a single 27x26 multiplier, one product per step at most
// a new item is taken in the accept step only; the result register frees the
// sequencer once loaded, so the next item can start while a result waits
// a stalled result holds the last step until the output register drains
// reset restores the register defaults and clears filter and integrator state
`include "assert_macros.svh"

module balance_cascade_pid (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic signed [15:0]               speed_left_i,
  input  logic signed [15:0]               speed_right_i,
  input  logic signed [16:0]               pitch_i,
  input  logic signed [15:0]               rate_pitch_i,
  input  logic signed [15:0]               rate_yaw_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [15:0]               drive_left_o,
  output logic signed [15:0]               drive_right_o,
  output logic signed [15:0]               speed_term_o,
  input  logic                             cfg_we_i,
  input  logic [bcp_pkg::CFG_INDEX_W-1:0]  cfg_index_i,
  input  logic [bcp_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam logic signed [18:0] LIM_POS = 19'(bcp_pkg::INTEGRAL_LIMIT);
  localparam logic signed [18:0] LIM_NEG = -19'(bcp_pkg::INTEGRAL_LIMIT);
  localparam logic signed [14:0] INTEG_MAX = 15'(bcp_pkg::INTEGRAL_LIMIT);
  localparam logic signed [14:0] INTEG_MIN = -15'(bcp_pkg::INTEGRAL_LIMIT);

  // configuration
  logic signed [16:0] mid_angle_q;
  logic signed [15:0] speed_goal_q;
  logic signed [26:0] upright_kp_q, upright_kd_q, speed_kp_q, speed_ki_q, turn_gain_q;

  // sequencer and loop state
  logic [bcp_pkg::STEP_W-1:0] step_q, step_d;
  logic                       out_valid_q, out_valid_d;
  logic signed [17:0]         filt_q, filt_d;
  logic signed [14:0]         integ_q, integ_d;

  // working registers
  logic signed [16:0] pitch_q;
  logic signed [15:0] rate_pitch_q, rate_yaw_q;
  logic signed [17:0] err_q, err_d;
  logic [19:0]        num_abs_q, num_abs_d;
  logic               num_neg_q, num_neg_d;
  logic signed [52:0] prod_q, prod_d;
  logic signed [53:0] acc_q, acc_d;
  logic signed [15:0] speed_q, speed_d;
  logic signed [24:0] diff_q, diff_d;
  logic signed [27:0] turn_q, turn_d;
  logic signed [29:0] up_q, up_d;
  logic signed [15:0] drive_left_q, drive_left_d;
  logic signed [15:0] drive_right_q, drive_right_d;
  logic signed [15:0] speed_term_q, speed_term_d;

  bcp_pkg::ctrl_word_t cw;
  logic                hold;
  logic signed [26:0]  mul_a;
  logic signed [25:0]  mul_b;
  logic signed [20:0]  num;
  logic signed [18:0]  integ_sum;
  logic signed [53:0]  prod_x, trunc_v;
  logic signed [30:0]  drv_l, drv_r;
  logic [16:0]         quot;

  assign cw   = bcp_pkg::ucode(step_q);
  assign hold = ((cw.seq == bcp_pkg::SEQ_WAIT_IN) && !in_valid_i) ||
                ((cw.seq == bcp_pkg::SEQ_WAIT_OUT) && out_valid_q && out_stall_i);

  assign in_stall_o    = (step_q != '0);
  assign out_valid_o   = out_valid_q;
  assign drive_left_o  = drive_left_q;
  assign drive_right_o = drive_right_q;
  assign speed_term_o  = speed_term_q;

  always_comb begin
    case (cw.mul_a)
      bcp_pkg::MA_RECIP:    mul_a = bcp_pkg::RECIP_10;
      bcp_pkg::MA_SPEED_KP: mul_a = speed_kp_q;
      bcp_pkg::MA_SPEED_KI: mul_a = speed_ki_q;
      bcp_pkg::MA_TURN:     mul_a = turn_gain_q;
      bcp_pkg::MA_UP_KP:    mul_a = upright_kp_q;
      bcp_pkg::MA_UP_KD:    mul_a = upright_kd_q;
      default:              mul_a = '0;
    endcase
    case (cw.mul_b)
      bcp_pkg::MB_NUM_ABS:    mul_b = {6'b0, num_abs_q};
      bcp_pkg::MB_FILT:       mul_b = {{8{filt_q[17]}}, filt_q};
      bcp_pkg::MB_INTEG:      mul_b = {{11{integ_q[14]}}, integ_q};
      bcp_pkg::MB_RATE_YAW:   mul_b = {{10{rate_yaw_q[15]}}, rate_yaw_q};
      bcp_pkg::MB_DIFF:       mul_b = {diff_q[24], diff_q};
      bcp_pkg::MB_RATE_PITCH: mul_b = {{10{rate_pitch_q[15]}}, rate_pitch_q};
      default:                mul_b = '0;
    endcase
  end

  assign prod_d = mul_a * mul_b;
  assign prod_x = {prod_q[52], prod_q};

  always_comb begin
    step_d        = step_q;
    out_valid_d   = out_valid_q && out_stall_i;
    filt_d        = filt_q;
    integ_d       = integ_q;
    err_d         = err_q;
    num_abs_d     = num_abs_q;
    num_neg_d     = num_neg_q;
    acc_d         = acc_q;
    speed_d       = speed_q;
    diff_d        = diff_q;
    turn_d        = turn_q;
    up_d          = up_q;
    drive_left_d  = drive_left_q;
    drive_right_d = drive_right_q;
    speed_term_d  = speed_term_q;
    num           = ({{3{err_q[17]}}, err_q} <<< 1) + {{3{err_q[17]}}, err_q} +
                    ({{3{filt_q[17]}}, filt_q} <<< 3) - {{3{filt_q[17]}}, filt_q};
    integ_sum     = {{4{integ_q[14]}}, integ_q} + {filt_q[17], filt_q};
    quot          = prod_q[40:24];
    trunc_v       = '0;
    drv_l         = {up_q[29], up_q} - {{3{turn_q[27]}}, turn_q};
    drv_r         = {up_q[29], up_q} + {{3{turn_q[27]}}, turn_q};

    if (!hold) begin
      unique case (cw.seq)
        bcp_pkg::SEQ_NEXT, bcp_pkg::SEQ_WAIT_IN: step_d = step_q + 1'b1;
        bcp_pkg::SEQ_WAIT_OUT, bcp_pkg::SEQ_RESTART: step_d = '0;
        default: step_d = '0;
      endcase

      unique case (cw.alu)
        bcp_pkg::ALU_ERR: begin
          err_d = {{2{speed_left_i[15]}}, speed_left_i} +
                  {{2{speed_right_i[15]}}, speed_right_i} -
                  {{2{speed_goal_q[15]}}, speed_goal_q};
        end
        bcp_pkg::ALU_NUM: begin
          num_neg_d = num[20];
          num_abs_d = num[20] ? 20'(-num) : num[19:0];
        end
        bcp_pkg::ALU_FILT: begin
          filt_d = num_neg_q ? -{1'b0, quot} : {1'b0, quot};
        end
        bcp_pkg::ALU_INTEG: begin
          if (integ_sum > LIM_POS) begin
            integ_d = LIM_POS[14:0];
          end else if (integ_sum < LIM_NEG) begin
            integ_d = LIM_NEG[14:0];
          end else begin
            integ_d = integ_sum[14:0];
          end
        end
        bcp_pkg::ALU_ACC_LOAD:    acc_d = prod_x;
        bcp_pkg::ALU_ACC_ADD:     acc_d = acc_q + prod_x;
        bcp_pkg::ALU_ACC_ADD_SH8: acc_d = acc_q + (prod_x <<< 8);
        bcp_pkg::ALU_SPEED: begin
          trunc_v = bcp_pkg::trunc_pow2(acc_q, 16);
          speed_d = bcp_pkg::sat16(trunc_v);
        end
        bcp_pkg::ALU_DIFF: begin
          diff_d = {{8{pitch_q[16]}}, pitch_q} - {{8{mid_angle_q[16]}}, mid_angle_q} -
                   {speed_q[15], speed_q, 8'b0};
        end
        bcp_pkg::ALU_TURN: begin
          trunc_v = bcp_pkg::trunc_pow2(prod_x, 16);
          turn_d  = -trunc_v[27:0];
        end
        bcp_pkg::ALU_UPRIGHT: begin
          trunc_v = bcp_pkg::trunc_pow2(acc_q, 24);
          up_d    = trunc_v[29:0];
        end
        bcp_pkg::ALU_OUT: begin
          drive_left_d  = bcp_pkg::sat16({{23{drv_l[30]}}, drv_l});
          drive_right_d = bcp_pkg::sat16({{23{drv_r[30]}}, drv_r});
          speed_term_d  = speed_q;
          out_valid_d   = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q         <= '0;
      out_valid_q    <= 1'b0;
      filt_q         <= '0;
      integ_q        <= '0;
      mid_angle_q    <= bcp_pkg::MID_ANGLE_RST;
      speed_goal_q   <= bcp_pkg::SPEED_GOAL_RST;
      upright_kp_q   <= bcp_pkg::UPRIGHT_KP_RST;
      upright_kd_q   <= bcp_pkg::UPRIGHT_KD_RST;
      speed_kp_q     <= bcp_pkg::SPEED_KP_RST;
      speed_ki_q     <= bcp_pkg::SPEED_KI_RST;
      turn_gain_q    <= bcp_pkg::TURN_GAIN_RST;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
      filt_q      <= filt_d;
      integ_q     <= integ_d;
      if (cfg_we_i) begin
        unique case (bcp_pkg::cfg_reg_e'(cfg_index_i))
          bcp_pkg::REG_MID_ANGLE:    mid_angle_q    <= cfg_data_i[16:0];
          bcp_pkg::REG_SPEED_GOAL:   speed_goal_q   <= cfg_data_i[15:0];
          bcp_pkg::REG_UPRIGHT_KP:   upright_kp_q   <= cfg_data_i;
          bcp_pkg::REG_UPRIGHT_KD:   upright_kd_q   <= cfg_data_i;
          bcp_pkg::REG_SPEED_KP:     speed_kp_q     <= cfg_data_i;
          bcp_pkg::REG_SPEED_KI:     speed_ki_q     <= cfg_data_i;
          bcp_pkg::REG_TURN_GAIN:    turn_gain_q    <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      pitch_q      <= pitch_i;
      rate_pitch_q <= rate_pitch_i;
      rate_yaw_q   <= rate_yaw_i;
    end
    err_q         <= err_d;
    num_abs_q     <= num_abs_d;
    num_neg_q     <= num_neg_d;
    if (cw.mul_en) begin
      prod_q <= prod_d;
    end
    acc_q         <= acc_d;
    speed_q       <= speed_d;
    diff_q        <= diff_d;
    turn_q        <= turn_d;
    up_q          <= up_d;
    drive_left_q  <= drive_left_d;
    drive_right_q <= drive_right_d;
    speed_term_q  <= speed_term_d;
  end

  `ASSERT_NEXT(a_accept_starts, clk_i, rst_ni, in_valid_i && !in_stall_o, step_q == 4'd1)
  `ASSERT_ALWAYS(a_integ_range, clk_i, rst_ni, integ_q <= INTEG_MAX && integ_q >= INTEG_MIN)
  `ASSERT_ALWAYS(a_filt_range, clk_i, rst_ni, filt_q <= 18'sd98303 && filt_q >= -18'sd98303)
  `ASSERT_IMPLY(a_result_from_last, clk_i, rst_ni, $rose(out_valid_q), $past(step_q) == bcp_pkg::LAST_STEP)

endmodule
